// File: sv/horspool_substring_search_macros.svh
// assertion helpers for the substring search block
`ifndef HORSPOOL_SUBSTRING_SEARCH_MACROS_SVH
`define HORSPOOL_SUBSTRING_SEARCH_MACROS_SVH

// implication checked on every clock edge outside reset
`define HSS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define HSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: sv/hss_pkg.sv
`timescale 1ns / 1ps
package hss_pkg;

    localparam int MaxData   = 4096;
    localparam int DataAw    = $clog2(MaxData);
    localparam int FillW     = DataAw + 1;
    localparam int Alphabet  = 256;

    localparam logic [1:0] MODE_FIND_EXACT = 2'd0;
    localparam logic [1:0] MODE_FIND_FOLD  = 2'd1;
    localparam logic [1:0] MODE_COUNT      = 2'd2;

    localparam logic REG_PATTERN_LEN = 1'b0;
    localparam logic REG_SEARCH_MODE = 1'b1;

    localparam logic MODE_PATTERN = 1'b0;
    localparam logic MODE_DATA    = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic clear_skip;   // sweep step: write entry at sweep index with pattern_len
        logic load_skip;    // write skip entry for pattern byte at pattern index
        logic start_pos;    // pos <= 0, base <= 0, sweep <= 0, clear hit, first and count
        logic read_cmp;     // issue reads of data[pos+i] and pattern[i]
        logic read_tail;    // issue read of data[pos+m-1]
        logic read_skip;    // issue skip table read for the tail byte
        logic advance;      // pos += skip
        logic next_i;       // i++
        logic clear_i;      // i <= 0
        logic record_hit;   // count/first update, base += pos+m, pos <= 0
        logic finish;       // load result register
        logic restart;      // clear fill and overflow
    } hss_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic sweep_done;
        logic build_done;
        logic pos_ok;       // pos <= len - m and m != 0
        logic byte_eq;
        logic i_last;       // i == m-1
        logic count_mode;
    } hss_stat_t;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
            r = c + 8'd32;
        return r;
    endfunction

endpackage

// File: sv/hss_datapath.sv
`timescale 1ns / 1ps
module hss_datapath (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_take,
    input  logic                   mode,
    input  logic [7:0]             byte_value,
    input  logic [7:0]             pattern_len_reg,
    input  logic [1:0]             search_mode_reg,
    input  hss_pkg::hss_cmd_t      cmd,
    output hss_pkg::hss_stat_t     stat,
    output logic                   found,
    output logic [11:0]            first_location,
    output logic [12:0]            match_count,
    output logic                   overflow
);

    logic [7:0] pattern_mem [hss_pkg::Alphabet];
    logic [7:0] skip_mem [hss_pkg::Alphabet];
    logic [7:0] data_mem [hss_pkg::MaxData];

    logic [7:0]               pfill_reg;
    logic [hss_pkg::FillW-1:0] dfill_reg;
    logic                     ovf_reg;
    logic [7:0]               idx_reg;     // build index, compare index
    logic [8:0]               sweep_reg;
    logic [hss_pkg::FillW-1:0] base_reg, pos_reg;
    logic [7:0]               d_rd_reg, p_rd_reg, skip_rd_reg;
    logic                     hit_reg;
    logic [hss_pkg::DataAw-1:0] first_reg;
    logic [12:0]              count_reg;
    logic                     fold;
    logic [7:0]               d_fold;
    logic [hss_pkg::FillW+1:0] end_pos, addr_full;
    logic [hss_pkg::FillW-1:0] len_rem;

    assign fold   = (search_mode_reg == hss_pkg::MODE_FIND_FOLD);
    assign d_fold = fold ? hss_pkg::lower_ascii(d_rd_reg) : d_rd_reg;
    assign len_rem = dfill_reg - base_reg;
    assign end_pos = {2'b00, pos_reg} + {{(hss_pkg::FillW-6){1'b0}}, pattern_len_reg};

    // status to the controller
    always_comb
    begin
        stat.sweep_done = sweep_reg[8];
        stat.build_done = ({1'b0, idx_reg} + 9'd1 >= {1'b0, pattern_len_reg});
        stat.pos_ok     = (pattern_len_reg != 8'd0) && (end_pos <= {2'b00, len_rem});
        stat.byte_eq    = (d_fold == p_rd_reg);
        stat.i_last     = ({1'b0, idx_reg} + 9'd1 == {1'b0, pattern_len_reg});
        stat.count_mode = (search_mode_reg == hss_pkg::MODE_COUNT);
    end

    // address of the byte being examined
    always_comb
    begin
        if (cmd.read_tail)
            addr_full = {2'b00, base_reg} + end_pos - 1'b1;
        else
            addr_full = {2'b00, base_reg} + {2'b00, pos_reg}
                        + {{(hss_pkg::FillW-6){1'b0}}, idx_reg};
    end

    // pattern and skip memories
    always_ff @(posedge clk)
    begin
        if (in_take && mode == hss_pkg::MODE_PATTERN)
            pattern_mem[pfill_reg] <= byte_value;
        if (cmd.clear_skip)
            skip_mem[sweep_reg[7:0]] <= pattern_len_reg;
        else if (cmd.load_skip)
            skip_mem[p_rd_reg] <= pattern_len_reg - 8'd1 - idx_reg;
        p_rd_reg <= pattern_mem[idx_reg];
        skip_rd_reg <= skip_mem[d_fold];
    end

    // data buffer
    always_ff @(posedge clk)
    begin
        if (in_take && mode == hss_pkg::MODE_DATA && !dfill_reg[hss_pkg::DataAw])
            data_mem[dfill_reg[hss_pkg::DataAw-1:0]] <= byte_value;
        d_rd_reg <= data_mem[addr_full[hss_pkg::DataAw-1:0]];
    end

    // counters and search registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pfill_reg <= '0;
            dfill_reg <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            sweep_reg <= '0;
            base_reg  <= '0;
            pos_reg   <= '0;
            hit_reg   <= 1'b0;
            first_reg <= '0;
            count_reg <= '0;
            found <= 1'b0;
            first_location <= '0;
            match_count <= '0;
            overflow <= 1'b0;
        end
        else
        begin
            if (in_take && mode == hss_pkg::MODE_PATTERN)
                pfill_reg <= pfill_reg + 8'd1;
            if (in_take && mode == hss_pkg::MODE_DATA)
            begin
                if (dfill_reg[hss_pkg::DataAw])
                    ovf_reg <= 1'b1;
                else
                    dfill_reg <= dfill_reg + 1'b1;
            end
            if (cmd.clear_skip)
                sweep_reg <= sweep_reg + 9'd1;
            if (cmd.clear_i)
                idx_reg <= '0;
            else if (cmd.next_i)
                idx_reg <= idx_reg + 8'd1;
            if (cmd.start_pos)
            begin
                sweep_reg <= '0;
                base_reg <= '0;
                pos_reg  <= '0;
                hit_reg  <= 1'b0;
                first_reg <= '0;
                count_reg <= '0;
                // last pattern byte returns the load index to the start
                if (mode == hss_pkg::MODE_PATTERN)
                    pfill_reg <= '0;
            end
            if (cmd.advance)
                pos_reg <= pos_reg + {{(hss_pkg::FillW-8){1'b0}}, skip_rd_reg};
            if (cmd.record_hit)
            begin
                if (!hit_reg)
                    first_reg <= base_reg[hss_pkg::DataAw-1:0] + pos_reg[hss_pkg::DataAw-1:0];
                hit_reg   <= 1'b1;
                count_reg <= count_reg + 13'd1;
                base_reg  <= end_pos[hss_pkg::FillW-1:0] + base_reg;
                pos_reg   <= '0;
            end
            if (cmd.finish)
            begin
                found <= hit_reg;
                first_location <= first_reg[11:0];
                match_count <= count_reg;
                overflow <= ovf_reg;
            end
            if (cmd.restart)
            begin
                dfill_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

endmodule

// File: sv/hss_control.sv
`timescale 1ns / 1ps
module hss_control (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               mode,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_ready,
    input  hss_pkg::hss_stat_t stat,
    output hss_pkg::hss_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_SWEEP, ST_BRD, ST_BWR, ST_CRD, ST_CMP,
        ST_TRD, ST_SRD, ST_ADV, ST_CHK, ST_DONE, ST_OUT
    } state_t;

    state_t state_reg;
    logic   search_reg;     // table rebuild is followed by a search
    logic   take;

    assign in_ready = (state_reg == ST_IDLE) && !out_valid;
    assign take = in_valid && in_ready;

    // command decode
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:  cmd.clear_i = 1'b1;
            ST_SWEEP: cmd.clear_skip = !stat.sweep_done;
            ST_BRD:   ;
            ST_BWR:   begin cmd.load_skip = 1'b1; cmd.next_i = 1'b1; end
            ST_CHK:   cmd.clear_i = 1'b1;
            ST_CRD:   cmd.read_cmp = 1'b1;
            ST_CMP:   cmd.next_i = stat.byte_eq && !stat.i_last;
            ST_TRD:   cmd.read_tail = 1'b1;
            ST_SRD:   cmd.read_skip = 1'b1;
            ST_ADV:   begin cmd.advance = 1'b1; cmd.clear_i = 1'b1; end
            ST_DONE:  begin cmd.finish = 1'b1; cmd.restart = 1'b1; end
            default:  ;
        endcase
        if (state_reg == ST_CMP && stat.byte_eq && stat.i_last)
            cmd.record_hit = 1'b1;
        if (take)
            cmd.start_pos = last_byte;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            search_reg <= 1'b0;
            out_valid  <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (take && last_byte)
                    begin
                        search_reg <= (mode == hss_pkg::MODE_DATA);
                        state_reg  <= ST_SWEEP;
                    end
                ST_SWEEP:
                    if (stat.sweep_done)
                        state_reg <= ST_BRD;
                // table entries are written for pattern bytes 0 .. len-2
                ST_BRD:   state_reg <= stat.build_done ? ST_CHK : ST_BWR;
                ST_BWR:   state_reg <= ST_BRD;
                ST_CHK:
                    if (!search_reg)
                        state_reg <= ST_IDLE;
                    else if (stat.pos_ok)
                        state_reg <= ST_CRD;
                    else
                        state_reg <= ST_DONE;
                ST_CRD:   state_reg <= ST_CMP;
                ST_CMP:
                    if (!stat.byte_eq)
                        state_reg <= ST_TRD;
                    else if (stat.i_last)
                        state_reg <= stat.count_mode ? ST_CHK : ST_DONE;
                    else
                        state_reg <= ST_CRD;
                ST_TRD:   state_reg <= ST_SRD;
                ST_SRD:   state_reg <= ST_ADV;
                ST_ADV:   state_reg <= ST_CHK;
                ST_DONE:
                begin
                    out_valid <= 1'b1;
                    state_reg <= ST_OUT;
                end
                ST_OUT:   state_reg <= ST_IDLE;
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// File: sv/horspool_substring_search.sv
`timescale 1ns / 1ps
// channel   signals                              direction
// input     in_valid in_ready mode byte_value    in
//           last_byte
// output    out_valid out_ready found            out
//           first_location match_count overflow
// config    cfg_valid cfg_ready cfg_index        in
//           cfg_data
// bytes load one per cycle while in_ready is high; the last byte of a block
// starts a skip table sweep over all 256 entries, a rebuild from the pattern
// bytes, then, for a data block, the search, which reads the data buffer
// through its single read port
// reset clears control and counters; buffers hold garbage until written
// input stalls while the table is rebuilt, a search runs or a result waits

`include "horspool_substring_search_macros.svh"

module horspool_substring_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic [7:0]  byte_value,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [11:0] first_location,
    output logic [12:0] match_count,
    output logic        overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic [7:0]         pattern_len_reg;
    logic [1:0]         search_mode_reg;
    hss_pkg::hss_cmd_t  cmd;
    hss_pkg::hss_stat_t stat;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_len_reg <= 8'd1;
            search_mode_reg <= hss_pkg::MODE_FIND_EXACT;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == hss_pkg::REG_PATTERN_LEN)
                pattern_len_reg <= cfg_data;
            else
                search_mode_reg <= cfg_data[1:0];
        end
    end

    hss_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    hss_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_take         (in_valid && in_ready),
        .mode            (mode),
        .byte_value      (byte_value),
        .pattern_len_reg (pattern_len_reg),
        .search_mode_reg (search_mode_reg),
        .cmd             (cmd),
        .stat            (stat),
        .found           (found),
        .first_location  (first_location),
        .match_count     (match_count),
        .overflow        (overflow)
    );

    `HSS_ASSERT_IMP(a_no_take_with_result, out_valid, !in_ready)
    `HSS_ASSERT_IMP(a_found_matches_count, out_valid, found == (match_count != 13'd0))
    `HSS_ASSERT_NEXT(a_one_step, cmd.finish, out_valid)

endmodule
